// ----- sv/png_scanline_unfilter_top_macros.svh -----
`ifndef PNG_SCANLINE_UNFILTER_TOP_MACROS_SVH
`define PNG_SCANLINE_UNFILTER_TOP_MACROS_SVH

// same-cycle implication
`define PSU_ASSERT_SAME(lbl, ck, rn, ante, cons, msg) \
	lbl: assert property (@(posedge ck) disable iff (!rn) (ante) |-> (cons)) else $error(msg);

// next-cycle implication
`define PSU_ASSERT_NEXT(lbl, ck, rn, ante, cons, msg) \
	lbl: assert property (@(posedge ck) disable iff (!rn) (ante) |=> (cons)) else $error(msg);

`endif

// ----- sv/psu_pkg.sv -----
`timescale 1ns / 1ps
`default_nettype none
package psu_pkg;

	localparam int COL_W = 13;
	localparam int BPP_W = 3;
	localparam int BYTE_W = 8;
	localparam int HIST_D = 4;

	typedef enum logic [2:0] {
		FLT_NONE  = 3'd0,
		FLT_SUB   = 3'd1,
		FLT_UP    = 3'd2,
		FLT_AVG   = 3'd3,
		FLT_PAETH = 3'd4
	} filt_t;

	typedef enum logic {
		REG_ROW_BYTES = 1'b0,
		REG_BPP       = 1'b1
	} cfg_reg_t;

	typedef struct packed {
		logic       is_err;
		logic       first_row;
		logic       has_left;
		logic [1:0] bsel;
		filt_t      filt;
		logic       last;
	} s1_ctl_t;

	typedef struct packed {
		filt_t             filt;
		logic [BYTE_W-1:0] raw;
		logic [BYTE_W-1:0] left;
		logic [BYTE_W-1:0] up;
		logic [BYTE_W-1:0] upleft;
	} pred_in_t;

endpackage
`default_nettype wire

// ----- sv/psu_line_buf.sv -----
`timescale 1ns / 1ps
`default_nettype none
module psu_line_buf #(
	parameter int DEPTH = 4096,
	parameter int AW = 12
) (
	input  wire logic          clk,
	input  wire logic          wr_en,
	input  wire logic [AW-1:0] wr_addr,
	input  wire logic [7:0]    wr_data,
	input  wire logic          rd_en,
	input  wire logic [AW-1:0] rd_addr,
	output logic      [7:0]    rd_data
);

	logic [7:0] mem [DEPTH];
	logic [7:0] rd_data_q;

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
		if (rd_en) begin
			rd_data_q <= mem[rd_addr];
		end
	end

	assign rd_data = rd_data_q;

endmodule
`default_nettype wire

// ----- sv/psu_predict.sv -----
`timescale 1ns / 1ps
`default_nettype none
module psu_predict (
	input  psu_pkg::pred_in_t pin,
	output logic [7:0]        result
);

	import psu_pkg::*;

	function automatic logic [9:0] abs10(input logic signed [9:0] v);
		logic signed [9:0] n;
		begin
			n = -v;
			abs10 = v[9] ? n : v;
		end
	endfunction

	logic signed [9:0] p;
	logic [9:0] da;
	logic [9:0] db;
	logic [9:0] dc;
	logic [8:0] avg_sum;
	logic [7:0] paeth;
	logic [7:0] pred;

	always_comb begin
		p  = $signed({2'b00, pin.left}) + $signed({2'b00, pin.up})
			- $signed({2'b00, pin.upleft});
		da = abs10(p - $signed({2'b00, pin.left}));
		db = abs10(p - $signed({2'b00, pin.up}));
		dc = abs10(p - $signed({2'b00, pin.upleft}));
		if (da <= db && da <= dc) begin
			paeth = pin.left;
		end else if (db <= dc) begin
			paeth = pin.up;
		end else begin
			paeth = pin.upleft;
		end
	end

	// average halves the sum
	assign avg_sum = {1'b0, pin.left} + {1'b0, pin.up};

	always_comb begin
		case (pin.filt)
			FLT_SUB:   pred = pin.left;
			FLT_UP:    pred = pin.up;
			FLT_AVG:   pred = avg_sum[8:1];
			FLT_PAETH: pred = paeth;
			default:   pred = 8'd0;
		endcase
	end

	assign result = pin.raw + pred;

endmodule
`default_nettype wire

// ----- sv/png_scanline_unfilter_top.sv -----
// two register stages: stage 1 and the result register; stage 1 holds its item while output stalls
// throughput: one input item per cycle unless stalled; valid filter bytes give no result
// the line buffer is one write port and one registered read port, read one byte ahead
// reset (arst_n low, asynchronous) clears row/filter control, history and valid flags
// row_bytes and bytes_per_pixel reset to 1; the line buffer is not cleared
`timescale 1ns / 1ps
`default_nettype none
module png_scanline_unfilter_top #(
	parameter int MAX_ROW_BYTES = 4096
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        cfg_we,
	input  wire logic        cfg_index,
	input  wire logic [12:0] cfg_data,
	input  wire logic        in_valid,
	output logic             in_ready,
	input  wire logic [7:0]  data_byte,
	input  wire logic        start_of_image,
	output logic             out_valid,
	input  wire logic        out_ready,
	output logic [7:0]       pixel_byte,
	output logic             end_of_row,
	output logic             status
);

	import psu_pkg::*;
	`include "png_scanline_unfilter_top_macros.svh"

	localparam int AW = (MAX_ROW_BYTES > 1) ? $clog2(MAX_ROW_BYTES) : 1;
	localparam logic [16:0] MAX_W = 17'(MAX_ROW_BYTES);

	logic [COL_W-1:0] row_bytes_q;
	logic [BPP_W-1:0] bpp_q;

	logic [COL_W-1:0] col_q;
	filt_t            filt_q;
	logic             await_q;
	logic             first_q;
	logic             err_q;

	logic [7:0] left_hist_q [HIST_D];
	logic [7:0] upleft_hist_q [HIST_D];

	logic           s1_valid_q;
	s1_ctl_t        ctl_s1;
	logic [7:0]     data_s1;
	logic [AW-1:0]  addr_s1;

	logic       out_valid_q;
	logic [7:0] pixel_byte_q;
	logic       end_of_row_q;
	logic       status_q;

	logic in_acc;
	logic s1_adv;
	logic err_eff;
	logic await_eff;
	logic is_data;
	logic is_bad;
	logic is_filt;
	logic [COL_W-1:0] rb13;
	logic [16:0] rb_eff;
	logic [16:0] col_ext;
	logic [16:0] col_inc;
	logic last;
	logic [BPP_W-1:0] bpp_eff;
	logic has_left;
	logic [AW-1:0] rd_addr;
	logic [7:0] rd_data;
	logic lb_wr_en;
	pred_in_t pin;
	logic [7:0] result;
	logic [7:0] up_val;

	// configuration
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			row_bytes_q <= COL_W'(1);
			bpp_q       <= BPP_W'(1);
		end else if (cfg_we) begin
			case (cfg_reg_t'(cfg_index))
				REG_ROW_BYTES: row_bytes_q <= cfg_data;
				REG_BPP:       bpp_q <= cfg_data[BPP_W-1:0];
				default:       ;
			endcase
		end
	end

	assign s1_adv   = s1_valid_q && (!out_valid_q || out_ready);
	assign in_ready = !s1_valid_q || s1_adv;
	assign in_acc   = in_valid && in_ready;

	assign err_eff   = err_q && !start_of_image;
	assign await_eff = await_q || start_of_image;
	assign is_data   = in_acc && !err_eff && !await_eff;
	assign is_bad    = in_acc && !err_eff && await_eff && (data_byte > 8'(FLT_PAETH));
	assign is_filt   = in_acc && !err_eff && await_eff && (data_byte <= 8'(FLT_PAETH));

	always_comb begin
		rb13 = (row_bytes_q == '0) ? COL_W'(1) : row_bytes_q;
		rb_eff = 17'(rb13);
		if (rb_eff > MAX_W) begin
			rb_eff = MAX_W;
		end
		col_ext = 17'(col_q);
		col_inc = col_ext + 17'd1;
		last = (col_inc >= rb_eff);
		if (bpp_q == '0) begin
			bpp_eff = BPP_W'(1);
		end else if (bpp_q > BPP_W'(HIST_D)) begin
			bpp_eff = BPP_W'(HIST_D);
		end else begin
			bpp_eff = bpp_q;
		end
		has_left = (col_ext >= 17'(bpp_eff));
		rd_addr = (col_ext >= MAX_W) ? AW'(MAX_W - 17'd1) : AW'(col_ext);
	end

	// row control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			col_q   <= '0;
			filt_q  <= FLT_NONE;
			await_q <= 1'b1;
			first_q <= 1'b1;
			err_q   <= 1'b0;
		end else if (in_acc) begin
			if (start_of_image) begin
				first_q <= 1'b1;
				err_q   <= 1'b0;
				await_q <= 1'b1;
				col_q   <= '0;
			end
			if (is_bad) begin
				err_q <= 1'b1;
			end
			if (is_filt) begin
				filt_q  <= filt_t'(data_byte[2:0]);
				await_q <= 1'b0;
				col_q   <= '0;
			end
			if (is_data) begin
				if (last) begin
					col_q   <= '0;
					await_q <= 1'b1;
					first_q <= 1'b0;
				end else begin
					col_q <= COL_W'(col_inc);
				end
			end
		end
	end

	// stage 1
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s1_valid_q <= 1'b0;
		end else if (in_acc) begin
			s1_valid_q <= is_data || is_bad;
		end else if (s1_adv) begin
			s1_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (in_acc) begin
			ctl_s1.is_err    <= is_bad;
			ctl_s1.first_row <= first_q;
			ctl_s1.has_left  <= has_left;
			ctl_s1.bsel      <= 2'(bpp_eff - BPP_W'(1));
			ctl_s1.filt      <= filt_q;
			ctl_s1.last      <= last;
			data_s1          <= data_byte;
			addr_s1          <= rd_addr;
		end
	end

	psu_line_buf #(
		.DEPTH(MAX_ROW_BYTES),
		.AW(AW)
	) u_line_buf (
		.clk(clk),
		.wr_en(lb_wr_en),
		.wr_addr(addr_s1),
		.wr_data(result),
		.rd_en(is_data),
		.rd_addr(rd_addr),
		.rd_data(rd_data)
	);

	assign lb_wr_en = s1_adv && !ctl_s1.is_err;
	assign up_val   = ctl_s1.first_row ? 8'd0 : rd_data;

	always_comb begin
		pin.filt   = ctl_s1.filt;
		pin.raw    = data_s1;
		pin.up     = up_val;
		pin.left   = ctl_s1.has_left ? left_hist_q[ctl_s1.bsel] : 8'd0;
		pin.upleft = ctl_s1.has_left ? upleft_hist_q[ctl_s1.bsel] : 8'd0;
	end

	psu_predict u_predict (
		.pin(pin),
		.result(result)
	);

	// neighbor history, most recent first
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < HIST_D; i++) begin
				left_hist_q[i]   <= '0;
				upleft_hist_q[i] <= '0;
			end
		end else if (is_filt) begin
			for (int i = 0; i < HIST_D; i++) begin
				left_hist_q[i]   <= '0;
				upleft_hist_q[i] <= '0;
			end
		end else if (lb_wr_en) begin
			for (int i = 1; i < HIST_D; i++) begin
				left_hist_q[i]   <= left_hist_q[i-1];
				upleft_hist_q[i] <= upleft_hist_q[i-1];
			end
			left_hist_q[0]   <= result;
			upleft_hist_q[0] <= up_val;
		end
	end

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (s1_adv) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (s1_adv) begin
			pixel_byte_q <= ctl_s1.is_err ? 8'd0 : result;
			end_of_row_q <= ctl_s1.is_err ? 1'b0 : ctl_s1.last;
			status_q     <= ctl_s1.is_err;
		end
	end

	assign out_valid  = out_valid_q;
	assign pixel_byte = pixel_byte_q;
	assign end_of_row = end_of_row_q;
	assign status     = status_q;

	`PSU_ASSERT_SAME(a_no_rw_clash, clk, arst_n, (lb_wr_en && is_data), (addr_s1 != rd_addr), "line buffer read and write hit the same entry")
	`PSU_ASSERT_NEXT(a_s1_hold, clk, arst_n, (s1_valid_q && out_valid_q && !out_ready), s1_valid_q, "stage 1 item lost under stall")
	`PSU_ASSERT_SAME(a_col_range, clk, arst_n, 1'b1, (col_ext < MAX_W), "column beyond line buffer")
	`PSU_ASSERT_SAME(a_err_zero, clk, arst_n, (out_valid_q && status_q), ((pixel_byte_q == 8'd0) && !end_of_row_q), "error item carries data")

endmodule
`default_nettype wire
